### rtl/ccd_pkg.sv
// Shared types and constants for the chunk container deframer.
`default_nettype none

package ccd_pkg;

   localparam int HDR_BYTES  = 8;
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);
   localparam logic [32:0] POS_MAX = '1;
   localparam logic [15:0] MAX_CHUNKS_RESET = 16'd256;

   typedef enum logic [1:0] {
      PH_ROOT = 2'd0,
      PH_HEAD = 2'd1,
      PH_SKIP = 2'd2,
      PH_STOP = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SHORT_ROOT = 3'd1,
      ST_SIZE_MISM  = 3'd2,
      ST_TRUNC_HDR  = 3'd3,
      ST_LIMIT      = 3'd4,
      ST_OUTSIDE    = 3'd5
   } status_type;

   typedef enum logic {
      KIND_CHUNK  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    item_kind;
      logic [31:0] chunk_ident;
      logic [31:0] chunk_length;
      logic [32:0] chunk_offset;
      status_type  status;
      logic [31:0] root_ident;
      logic [31:0] root_length;
      logic [15:0] chunks_found;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic    w0_valid;
      rsp_type w0_data;
      logic    w1_valid;
      rsp_type w1_data;
   } rsp_push_type;

endpackage

`default_nettype wire

### rtl/chunk_container_deframer.sv
// Top level of the chunk container deframer: header parser, limits, response queue.
`default_nettype none

// Chunk container deframer. Takes a container file one byte per word on the
// req_ channel (req_is_last marks the final byte) and parses an 8-byte
// little-endian root header (id, size) followed by child chunks, each an
// 8-byte header and a skipped payload. Every valid child yields a descriptor
// word on rsp_ (id, size, payload offset within the file); the byte marked
// last yields a final status word (last_result = 1) after any descriptor of
// that same byte, and the parser then returns to its reset state for the next
// file. The first error is sticky and stops further descriptors. Throughput
// is one byte per clock while req_ready is high: each byte is parsed
// combinationally against the parser state registers and its results are
// written straight into a four-word response queue. req_ready stays high
// while the queue has room for two words, so a stalled rsp_ side only backs
// up the input once less room remains. Each result word is registered into
// the queue. max_chunks must be written through csr_wr_en/csr_wr_data only
// while the block is idle; the block does not enforce this. Reset value: 256.
module chunk_container_deframer #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_is_last,
   // result output
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_item_kind,
   output logic [31:0]      rsp_chunk_ident,
   output logic [31:0]      rsp_chunk_length,
   output logic [32:0]      rsp_chunk_offset,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_root_ident,
   output logic [31:0]      rsp_root_length,
   output logic [15:0]      rsp_chunks_found,
   output logic             rsp_last_result,
   // config
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import ccd_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   // parser state
   logic [15:0]            max_chunks_ff;
   logic [32:0]            pos_ff,      pos_in;
   logic [63:0]            hdr_ff,      hdr_in;
   phase_type              phase_ff,    phase_in;
   logic [2:0]             hcnt_ff,     hcnt_in;
   logic [31:0]            root_id_ff,  root_id_in;
   logic [31:0]            root_len_ff, root_len_in;
   logic [32:0]            root_end_ff, root_end_in;   // root size + 8, file end
   logic [31:0]            left_ff,     left_in;
   logic [COUNT_WIDTH-1:0] child_ff,    child_in;
   status_type             err_ff,      err_in;

   logic                   accept;
   logic [32:0]            next_pos;
   logic [63:0]            shift_new;
   logic [31:0]            hdr_id;
   logic [31:0]            hdr_sz;
   logic [33:0]            chunk_end;
   logic                   desc_v;
   logic                   fin_v;
   rsp_type                desc;
   rsp_type                fin;
   status_type             fin_st;
   rsp_push_type           push;
   rsp_type                rsp_word;

   assign accept    = req_valid & req_ready;
   assign next_pos  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 33'd1;
   assign shift_new = {req_data_byte, hdr_ff[63:8]};
   assign hdr_id    = shift_new[31:0];
   assign hdr_sz    = shift_new[63:32];
   assign chunk_end = {1'b0, next_pos} + {2'b00, hdr_sz};

   always_comb begin
      pos_in      = pos_ff;
      hdr_in      = hdr_ff;
      phase_in    = phase_ff;
      hcnt_in     = hcnt_ff;
      root_id_in  = root_id_ff;
      root_len_in = root_len_ff;
      root_end_in = root_end_ff;
      left_in     = left_ff;
      child_in    = child_ff;
      err_in      = err_ff;
      desc_v      = 1'b0;
      fin_v       = 1'b0;
      fin_st      = ST_OK;

      desc              = '0;
      desc.item_kind    = KIND_CHUNK;
      desc.chunk_ident  = hdr_id;
      desc.chunk_length = hdr_sz;
      desc.chunk_offset = next_pos;
      desc.status       = ST_OK;
      desc.root_ident   = root_id_ff;
      desc.root_length  = root_len_ff;

      if (accept) begin
         unique case (phase_ff)
            PH_ROOT, PH_HEAD: begin
               hdr_in  = shift_new;
               hcnt_in = hcnt_ff + 3'd1;
               // eighth header byte: header complete
               if (hcnt_ff == 3'd7) begin
                  priority if (phase_ff == PH_ROOT) begin
                     root_id_in  = hdr_id;
                     root_len_in = hdr_sz;
                     root_end_in = {1'b0, hdr_sz} + 33'(HDR_BYTES);
                     phase_in    = PH_HEAD;
                  end else if (CMP_W'(child_ff) >= CMP_W'(max_chunks_ff)) begin
                     err_in   = ST_LIMIT;
                     phase_in = PH_STOP;
                  end else if (chunk_end > {1'b0, root_end_ff}) begin
                     err_in   = ST_OUTSIDE;
                     phase_in = PH_STOP;
                  end else begin
                     desc_v   = 1'b1;
                     child_in = child_ff + 1'b1;
                     left_in  = hdr_sz;
                     phase_in = (hdr_sz != '0) ? PH_SKIP : PH_HEAD;
                  end
               end
            end
            PH_SKIP: begin
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  phase_in = PH_HEAD;
               end
            end
            PH_STOP: begin
               // errored: bytes only counted
            end
            default: begin
            end
         endcase
         pos_in = next_pos;

         if (req_is_last) begin
            fin_v = 1'b1;
            priority if (pos_in < 33'(HDR_BYTES)) begin
               fin_st = ST_SHORT_ROOT;
            end else if (pos_in != root_end_in) begin
               fin_st = ST_SIZE_MISM;
            end else if (err_in != ST_OK) begin
               fin_st = err_in;
            end else if (phase_in == PH_HEAD && hcnt_in != 3'd0) begin
               fin_st = ST_TRUNC_HDR;
            end else if (phase_in == PH_SKIP) begin
               fin_st = ST_OUTSIDE;
            end else begin
               fin_st = ST_OK;
            end
            // back to reset state for the next file
            pos_in      = '0;
            hdr_in      = '0;
            phase_in    = PH_ROOT;
            hcnt_in     = '0;
            root_id_in  = '0;
            root_len_in = '0;
            root_end_in = 33'(HDR_BYTES);
            left_in     = '0;
            child_in    = '0;
            err_in      = ST_OK;
         end
      end

      fin              = '0;
      fin.item_kind    = KIND_STATUS;
      fin.status       = fin_st;
      fin.root_ident   = accept && (phase_ff == PH_ROOT) && (hcnt_ff == 3'd7)
                         ? hdr_id : root_id_ff;
      fin.root_length  = accept && (phase_ff == PH_ROOT) && (hcnt_ff == 3'd7)
                         ? hdr_sz : root_len_ff;
      fin.chunks_found = 16'(desc_v ? child_ff + 1'b1 : child_ff);
      fin.last_result  = 1'b1;
   end

   // descriptor goes first when both come from one byte
   always_comb begin
      push.w0_valid = desc_v | fin_v;
      push.w0_data  = desc_v ? desc : fin;
      push.w1_valid = desc_v & fin_v;
      push.w1_data  = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chunks_ff <= MAX_CHUNKS_RESET;
      end else if (csr_wr_en) begin
         max_chunks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hdr_ff      <= '0;
         phase_ff    <= PH_ROOT;
         hcnt_ff     <= '0;
         root_id_ff  <= '0;
         root_len_ff <= '0;
         root_end_ff <= 33'(HDR_BYTES);
         left_ff     <= '0;
         child_ff    <= '0;
         err_ff      <= ST_OK;
      end else begin
         pos_ff      <= pos_in;
         hdr_ff      <= hdr_in;
         phase_ff    <= phase_in;
         hcnt_ff     <= hcnt_in;
         root_id_ff  <= root_id_in;
         root_len_ff <= root_len_in;
         root_end_ff <= root_end_in;
         left_ff     <= left_in;
         child_ff    <= child_in;
         err_ff      <= err_in;
      end
   end

   ccd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_two  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_word)
   );

   assign rsp_item_kind    = rsp_word.item_kind;
   assign rsp_chunk_ident  = rsp_word.chunk_ident;
   assign rsp_chunk_length = rsp_word.chunk_length;
   assign rsp_chunk_offset = rsp_word.chunk_offset;
   assign rsp_status       = rsp_word.status;
   assign rsp_root_ident   = rsp_word.root_ident;
   assign rsp_root_length  = rsp_word.root_length;
   assign rsp_chunks_found = rsp_word.chunks_found;
   assign rsp_last_result  = rsp_word.last_result;

endmodule

`default_nettype wire

### rtl/ccd_rsp_fifo.sv
// Response queue: takes up to two words per cycle, delivers one per cycle while out_ready is high.
`default_nettype none

module ccd_rsp_fifo (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ccd_pkg::rsp_push_type push,
   output logic                room_two,
   output logic                out_valid,
   input  wire logic           out_ready,
   output ccd_pkg::rsp_type    out_data
);
   import ccd_pkg::*;

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   head_ff, head_in;
   logic [RSP_PTR_W-1:0]   tail_ff, tail_in;
   logic [RSP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   pop;
   logic [RSP_PTR_W-1:0]   tail_next;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[head_ff];
   assign pop       = out_valid & out_ready;
   assign room_two  = (cnt_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign tail_next = tail_ff + 1'b1;

   always_comb begin
      head_in = pop ? head_ff + 1'b1 : head_ff;
      tail_in = tail_ff + RSP_PTR_W'(push.w0_valid) + RSP_PTR_W'(push.w1_valid);
      cnt_in  = cnt_ff + RSP_CNT_W'(push.w0_valid) + RSP_CNT_W'(push.w1_valid)
                - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.w0_valid) begin
         mem_ff[tail_ff] <= push.w0_data;
      end
      if (push.w1_valid) begin
         mem_ff[tail_next] <= push.w1_data;
      end
   end

endmodule

`default_nettype wire
